// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the monitor RTL, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg
// Types and constants of the delayed threshold monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtm_pkg;

   localparam int NUM_SETUP_REGS = 8;
   localparam int SETUP_W        = 50;
   localparam int CSR_IDX_W      = 3;
   localparam int CHAN_W         = 3;
   localparam int VALUE_W        = 16;

   localparam logic [VALUE_W-1:0] DISARMED_COUNT = 16'hFFFF;

   // command codes
   typedef enum logic [0:0] {
      CMD_EVAL  = 1'b0,
      CMD_REARM = 1'b1
   } cmd_type;

   // compare modes
   typedef enum logic [1:0] {
      MODE_EQ    = 2'd0,
      MODE_NE    = 2'd1,
      MODE_ABOVE = 2'd2,
      MODE_BELOW = 2'd3
   } mode_type;

   // packed setup word, argument in the top bits
   typedef struct packed {
      logic [VALUE_W-1:0] argument;
      logic [VALUE_W-1:0] delay;
      logic [VALUE_W-1:0] threshold;
      mode_type           mode;
   } setup_type;

   // per-monitor state entry
   typedef struct packed {
      logic               armed;
      logic [VALUE_W-1:0] count;
   } state_type;

   localparam state_type STATE_RESET = '{armed: 1'b1, count: '0};

   // evaluation outcome
   typedef struct packed {
      logic               wr_en;
      state_type          next_state;
      logic               fired;
      logic [VALUE_W-1:0] argument;
   } eval_type;

endpackage

// File: sv/delayed_threshold_monitor_unit.sv
// ----------------------------------------------------------------------------
// delayed_threshold_monitor_unit
// Eight-way threshold monitor with persistence delay, memory-held state
// ----------------------------------------------------------------------------
// Usage
//   req_* carries one command per item: evaluate a sample for a channel, or
//   rearm that channel. rsp_* returns exactly one result per item, in order:
//   fired flag, channel and the action argument (zero when not fired).
//   csr_* writes the packed setup word of one monitor; write only while idle.
// Timing
//   The state memory is read at the edge that accepts an item, the evaluate
//   stage then works on it and the edge on which it fires loads the output
//   register. One item per cycle is sustained while rsp_ready is high: the
//   memory has separate read and write ports, and the last write is
//   forwarded to a following item on the same channel.
// Reset and stall
//   Reset clears all setup words and marks every monitor armed with a zero
//   count through per-entry valid bits, so no clearing pass is needed. When
//   rsp_ready is low the result holds, the evaluate stage holds one more item,
//   and req_ready drops once both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module delayed_threshold_monitor_unit #(
   parameter int NUM_MONITORS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic [dtm_pkg::CHAN_W-1:0]           req_channel,
   input  logic [dtm_pkg::VALUE_W-1:0]          req_sample_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_fired,
   output logic [dtm_pkg::CHAN_W-1:0]           rsp_fired_channel,
   output logic [dtm_pkg::VALUE_W-1:0]          rsp_action_argument,
   input  logic                                 csr_we,
   input  logic [dtm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dtm_pkg::SETUP_W-1:0]          csr_wdata
);

   localparam int AW = (NUM_MONITORS > 1) ? $clog2(NUM_MONITORS) : 1;

   dtm_pkg::setup_type                setup_ff [dtm_pkg::NUM_SETUP_REGS];

   logic                              s1_valid_ff, s1_valid_in;
   dtm_pkg::cmd_type                  s1_cmd_ff;
   logic [dtm_pkg::CHAN_W-1:0]        s1_channel_ff;
   logic [dtm_pkg::VALUE_W-1:0]       s1_sample_ff;

   logic                              fwd_valid_ff;
   logic [AW-1:0]                     fwd_addr_ff;
   dtm_pkg::state_type                fwd_data_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_fired_ff;
   logic [dtm_pkg::CHAN_W-1:0]        rsp_channel_ff;
   logic [dtm_pkg::VALUE_W-1:0]       rsp_argument_ff;

   logic                              req_fire;
   logic                              s1_fire;
   logic                              s1_in_range;
   logic [AW-1:0]                     s1_addr;
   dtm_pkg::state_type                mem_rd_data;
   dtm_pkg::state_type                cur_state;
   dtm_pkg::eval_type                 eval_res;
   logic                              mem_wr_en;

   // handshake
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // setup registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dtm_pkg::NUM_SETUP_REGS; i++) begin
            setup_ff[i] <= '0;
         end
      end else if (csr_we) begin
         setup_ff[csr_index] <= dtm_pkg::setup_type'(csr_wdata);
      end
   end

   // evaluate stage item registers
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff     <= dtm_pkg::cmd_type'(req_cmd);
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample_value;
      end
   end

   assign s1_in_range = ({1'b0, s1_channel_ff} < (dtm_pkg::CHAN_W + 1)'(NUM_MONITORS));
   assign s1_addr     = s1_channel_ff[AW-1:0];
   assign mem_wr_en   = s1_fire && eval_res.wr_en;

   // state memory
   dtm_state_mem #(
      .DEPTH (NUM_MONITORS),
      .AW    (AW)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (req_channel[AW-1:0]),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_addr),
      .wr_data (eval_res.next_state)
   );

   // last write kept for forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (mem_wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= eval_res.next_state;
      end
   end

   assign cur_state = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff : mem_rd_data;

   // compare and update
   dtm_eval u_eval (
      .in_range     (s1_in_range),
      .cmd          (s1_cmd_ff),
      .sample_value (s1_sample_ff),
      .setup        (setup_ff[s1_channel_ff]),
      .cur_state    (cur_state),
      .result       (eval_res)
   );

   // output register
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_fired_ff    <= eval_res.fired;
         rsp_channel_ff  <= s1_channel_ff;
         rsp_argument_ff <= eval_res.argument;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fired           = rsp_fired_ff;
   assign rsp_fired_channel   = rsp_channel_ff;
   assign rsp_action_argument = rsp_argument_ff;

   // checks
   `ASSERT_IMPL(a_quiet_arg, clock, reset, rsp_valid && !rsp_fired, rsp_action_argument == '0)
   `ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_fire, s1_valid_ff && $stable(s1_channel_ff))
   `ASSERT_IMPL(a_fire_disarms, clock, reset, mem_wr_en && eval_res.fired, !eval_res.next_state.armed && eval_res.next_state.count == dtm_pkg::DISARMED_COUNT)
   `ASSERT_IMPL(a_empty_ready, clock, reset, !s1_valid_ff, req_ready)

endmodule

// File: sv/dtm_state_mem.sv
// ----------------------------------------------------------------------------
// dtm_state_mem
// Monitor state memory, registered read, valid bits per entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtm_state_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output dtm_pkg::state_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  dtm_pkg::state_type  wr_data
);

   dtm_pkg::state_type mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   dtm_pkg::state_type rd_q_ff;
   logic               rd_valid_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // entries never written read as the reset state
   assign rd_data = rd_valid_ff ? rd_q_ff : dtm_pkg::STATE_RESET;

endmodule

// File: sv/dtm_eval.sv
// ----------------------------------------------------------------------------
// dtm_eval
// Threshold compare and persistence counter update for one item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtm_eval (
   input  logic                          in_range,
   input  dtm_pkg::cmd_type              cmd,
   input  logic [dtm_pkg::VALUE_W-1:0]   sample_value,
   input  dtm_pkg::setup_type            setup,
   input  dtm_pkg::state_type            cur_state,
   output dtm_pkg::eval_type             result
);

   logic cond;

   // compare against threshold
   always_comb begin
      unique case (setup.mode)
         dtm_pkg::MODE_EQ:    cond = (sample_value == setup.threshold);
         dtm_pkg::MODE_NE:    cond = (sample_value != setup.threshold);
         dtm_pkg::MODE_ABOVE: cond = (sample_value >  setup.threshold);
         dtm_pkg::MODE_BELOW: cond = (sample_value <  setup.threshold);
         default:             cond = 1'b0;
      endcase
   end

   // next state and fire decision
   always_comb begin
      result.wr_en      = in_range;
      result.next_state = cur_state;
      result.fired      = 1'b0;
      result.argument   = '0;
      if (in_range) begin
         priority if (cmd == dtm_pkg::CMD_REARM || !cond) begin
            result.next_state = dtm_pkg::STATE_RESET;
         end else if (cur_state.armed) begin
            if (cur_state.count >= setup.delay) begin
               result.next_state = '{armed: 1'b0, count: dtm_pkg::DISARMED_COUNT};
               result.fired      = 1'b1;
               result.argument   = setup.argument;
            end else begin
               result.next_state.count = cur_state.count + 16'd1;
            end
         end else begin
            // disarmed with the condition holding: state unchanged
            result.next_state = cur_state;
         end
      end
   end

endmodule
